// ----- hw/rtl/rpoc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpoc_pkg
// Shared types and constants of the RTP packet order classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rpoc_pkg;

    // configuration register indexes
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_CODEC_RATE       = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_MS         = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_SAMPLES    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SEQ_LIMIT        = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_OUT_RATE_KHZ     = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_BYTES_PER_SAMPLE = 3'd5;
    localparam int CfgDataW = 18;

    // reset values of the configuration registers
    localparam logic [17:0] CODEC_RATE_RST       = 18'd8000;
    localparam logic [7:0]  FRAME_MS_RST         = 8'd20;
    localparam logic [15:0] FRAME_SAMPLES_RST    = 16'd160;
    localparam logic [11:0] SEQ_LIMIT_RST        = 12'd50;
    localparam logic [7:0]  OUT_RATE_KHZ_RST     = 8'd48;
    localparam logic [3:0]  BYTES_PER_SAMPLE_RST = 4'd2;

    // packet case codes
    localparam logic [2:0] PCASE_NEW  = 3'd0;
    localparam logic [2:0] PCASE_NEXT = 3'd1;
    localparam logic [2:0] PCASE_JUMP = 3'd2;
    localparam logic [2:0] PCASE_OLD  = 3'd3;
    localparam logic [2:0] PCASE_DUP  = 3'd4;

    // payload type held after reset; no 7-bit type matches it
    localparam logic [7:0] PT_NONE = 8'd255;

    // |t| * 1000 needs at most 41 bits
    localparam int DvdW = 41;

    localparam logic signed [55:0] OFFSET_MAX = 56'sd2199023255551;
    localparam logic signed [55:0] OFFSET_MIN = -56'sd2199023255552;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [17:0] codec_rate;
        logic [7:0]  frame_ms;
        logic [15:0] frame_samples;
        logic [11:0] seq_limit;
        logic [7:0]  out_rate_khz;
        logic [3:0]  bytes_per_sample;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic               zero;   // payload type change: all-zero result
        logic [2:0]         pcase;
        logic signed [16:0] lost;
        logic signed [31:0] t;
    } t_job;

endpackage

`default_nettype wire

// ----- hw/rtl/rtp_packet_order_classifier_core.sv -----
// ----------------------------------------------------------------------------
// rtp_packet_order_classifier_core
// Classifies received RTP headers as new flow, next, jump, old or duplicate
// and reports packets presumed lost and the byte offset jump.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         i_valid / o_ready     i_seq_num, i_timestamp, i_payload_type
//  result    out        o_valid / i_ready     o_packet_case, o_offset_jump, o_lost_count
//  config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
//  In the back end an item passes one load, 41 steps of the bit-serial
//  divider, one subtract, one multiply and one output load; the divider
//  sets the sustained rate. Payload type changes skip to the output load.
//  The front classifies up to one item per cycle into the queue while it
//  has room. Synchronous active-low reset; no clearing pass. The queue lets
//  the front keep accepting while the back stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_packet_order_classifier_core import rpoc_pkg::*; #(
    parameter int Q_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [CfgIdxW-1:0]  i_cfg_idx,
    input  wire  [CfgDataW-1:0] i_cfg_data,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [15:0]         i_seq_num,
    input  wire  [31:0]         i_timestamp,
    input  wire  [6:0]          i_payload_type,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [2:0]          o_packet_case,
    output logic signed [41:0]  o_offset_jump,
    output logic signed [16:0]  o_lost_count
);

    t_cfg r_cfg;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.codec_rate       <= CODEC_RATE_RST;
            r_cfg.frame_ms         <= FRAME_MS_RST;
            r_cfg.frame_samples    <= FRAME_SAMPLES_RST;
            r_cfg.seq_limit        <= SEQ_LIMIT_RST;
            r_cfg.out_rate_khz     <= OUT_RATE_KHZ_RST;
            r_cfg.bytes_per_sample <= BYTES_PER_SAMPLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CODEC_RATE:       r_cfg.codec_rate       <= i_cfg_data[17:0];
                CFG_FRAME_MS:         r_cfg.frame_ms         <= i_cfg_data[7:0];
                CFG_FRAME_SAMPLES:    r_cfg.frame_samples    <= i_cfg_data[15:0];
                CFG_SEQ_LIMIT:        r_cfg.seq_limit        <= i_cfg_data[11:0];
                CFG_OUT_RATE_KHZ:     r_cfg.out_rate_khz     <= i_cfg_data[7:0];
                CFG_BYTES_PER_SAMPLE: r_cfg.bytes_per_sample <= i_cfg_data[3:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    rpoc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_seq_num      (i_seq_num),
        .i_timestamp    (i_timestamp),
        .i_payload_type (i_payload_type),
        .i_q_full       (w_full),
        .o_push         (w_push),
        .o_job          (w_job_in)
    );

    rpoc_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    rpoc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_empty     (w_empty),
        .i_job         (w_job_out),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_packet_case (o_packet_case),
        .o_offset_jump (o_offset_jump),
        .o_lost_count  (o_lost_count)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rpoc_front.sv -----
// ----------------------------------------------------------------------------
// rpoc_front
// Takes an RTP header, compares it with the last stored header, classifies
// it and pushes a job to the queue. Holds the per-flow state.
// ----------------------------------------------------------------------------
`default_nettype none

module rpoc_front import rpoc_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cfg        i_cfg,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [15:0] i_seq_num,
    input  wire  [31:0] i_timestamp,
    input  wire  [6:0]  i_payload_type,
    input  wire         i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic        r_hold_vld;
    logic [15:0] r_seq;
    logic [31:0] r_ts;
    logic [6:0]  r_pt;
    logic [7:0]  r_prev_pt;
    logic [31:0] r_prev_ts;
    logic [15:0] r_prev_seq;

    logic signed [17:0] w_d_raw;
    logic signed [17:0] w_d;
    logic [16:0]        w_abs_raw;
    logic [16:0]        w_abs;
    logic [16:0]        w_span;
    logic signed [31:0] w_t;
    logic signed [32:0] w_t33;
    logic [32:0]        w_abs_t;
    logic [27:0]        w_lim;
    logic               w_new;
    logic               w_pt_chg;
    logic [2:0]         w_pcase;

    assign o_push  = r_hold_vld && !i_q_full;
    assign o_ready = !r_hold_vld || o_push;

    assign w_pt_chg = ({1'b0, r_pt} != r_prev_pt);

    // sequence distance with 16-bit wrap correction
    assign w_d_raw   = $signed({2'b00, r_seq}) - $signed({2'b00, r_prev_seq});
    assign w_abs_raw = w_d_raw[17] ? 17'(-w_d_raw) : w_d_raw[16:0];
    assign w_span    = 17'd65535 - 17'(i_cfg.seq_limit);
    assign w_d       = (w_abs_raw > w_span)
                     ? (w_d_raw[17] ? w_d_raw + 18'sd65536 : w_d_raw - 18'sd65536)
                     : w_d_raw;
    assign w_abs     = w_d[17] ? 17'(-w_d) : w_d[16:0];

    assign w_t     = $signed(r_ts - r_prev_ts);
    assign w_t33   = {w_t[31], w_t};
    assign w_abs_t = w_t33[32] ? 33'(-w_t33) : 33'(w_t33);
    assign w_lim   = {16'd0, i_cfg.seq_limit} * {12'd0, i_cfg.frame_samples};

    assign w_new = (w_abs_t > {5'b0, w_lim}) || (w_abs > {5'b0, i_cfg.seq_limit});

    always_comb begin
        if (w_new) begin
            w_pcase = PCASE_NEW;
        end else if (!w_d[17] && w_d > 18'sd1) begin
            w_pcase = PCASE_JUMP;
        end else if (w_d == 18'sd1) begin
            w_pcase = PCASE_NEXT;
        end else if (w_d[17]) begin
            w_pcase = PCASE_OLD;
        end else begin
            w_pcase = PCASE_DUP;
        end
    end

    always_comb begin
        o_job.zero  = w_pt_chg;
        o_job.pcase = w_pt_chg ? PCASE_NEW : w_pcase;
        o_job.lost  = w_pt_chg ? 17'sd0 : 17'(w_d - 18'sd1);
        o_job.t     = w_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_prev_pt  <= PT_NONE;
            r_prev_ts  <= '0;
            r_prev_seq <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_hold_vld <= 1'b1;
            end else if (o_push) begin
                r_hold_vld <= 1'b0;
            end
            if (o_push) begin
                // old packets leave the state alone
                if (w_pt_chg || w_pcase != PCASE_OLD) begin
                    r_prev_ts  <= r_ts;
                    r_prev_seq <= r_seq;
                end
                if (w_pt_chg) begin
                    r_prev_pt <= {1'b0, r_pt};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_seq <= i_seq_num;
            r_ts  <= i_timestamp;
            r_pt  <= i_payload_type;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rpoc_queue.sv -----
// ----------------------------------------------------------------------------
// rpoc_queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rpoc_queue import rpoc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_job  i_job,
    output logic  o_full,
    input  wire   i_pop,
    output t_job  o_job,
    output logic  o_empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rpoc_back.sv -----
// ----------------------------------------------------------------------------
// rpoc_back
// Turns a classified item into its result: |t|*1000 divided by the codec
// rate bit-serially, less the frame length, then scaled to a byte offset and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module rpoc_back import rpoc_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cfg               i_cfg,
    input  wire                i_q_empty,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [2:0]         o_packet_case,
    output logic signed [41:0] o_offset_jump,
    output logic signed [16:0] o_lost_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MS,
        S_SCALE,
        S_OUT
    } t_state;

    localparam int CntW = $clog2(DvdW);

    t_state             r_state;
    logic               r_zero;
    logic               r_neg;
    logic [2:0]         r_pcase;
    logic signed [16:0] r_lost;
    logic [DvdW-1:0]    r_dvd;      // dividend, quotient shifts in from the bottom
    logic [17:0]        r_rem;
    logic [CntW-1:0]    r_cnt;
    logic [11:0]        r_k;
    logic signed [42:0] r_diff;
    logic signed [55:0] r_prod;
    logic               r_out_vld;
    logic [2:0]         r_out_case;
    logic signed [41:0] r_out_jump;
    logic signed [16:0] r_out_lost;

    logic [31:0]        w_mag;
    logic [DvdW-1:0]    w_mag_k;
    logic [18:0]        w_rem_sh;
    logic               w_ge;
    logic [18:0]        w_rem_sub;
    logic [DvdW-1:0]    w_q;
    logic signed [42:0] w_ms;
    logic signed [41:0] w_sat;
    logic               w_out_free;

    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign w_out_free = !r_out_vld || i_ready;

    assign w_mag   = i_job.t[31] ? 32'(-i_job.t) : 32'(i_job.t);
    assign w_mag_k = {9'd0, w_mag} * 41'd1000;

    // one restoring division step
    assign w_rem_sh  = {r_rem, r_dvd[DvdW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, i_cfg.codec_rate});
    assign w_rem_sub = w_rem_sh - {1'b0, i_cfg.codec_rate};

    assign w_q  = (i_cfg.codec_rate == '0) ? '0 : r_dvd;
    assign w_ms = r_neg ? -$signed({2'b00, w_q}) : $signed({2'b00, w_q});

    always_comb begin
        if (r_prod > OFFSET_MAX) begin
            w_sat = OFFSET_MAX[41:0];
        end else if (r_prod < OFFSET_MIN) begin
            w_sat = OFFSET_MIN[41:0];
        end else begin
            w_sat = r_prod[41:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= i_job.zero ? S_OUT : S_DIV;
                        r_cnt   <= '0;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CntW'(DvdW - 1)) begin
                        r_state <= S_MS;
                    end
                end
                S_MS: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    r_zero  <= i_job.zero;
                    r_neg   <= i_job.t[31];
                    r_pcase <= i_job.pcase;
                    r_lost  <= i_job.lost;
                    r_dvd   <= w_mag_k;
                    r_rem   <= '0;
                    r_k     <= {4'd0, i_cfg.out_rate_khz} * {8'd0, i_cfg.bytes_per_sample};
                end
            end
            S_DIV: begin
                r_rem <= w_ge ? w_rem_sub[17:0] : w_rem_sh[17:0];
                r_dvd <= {r_dvd[DvdW-2:0], w_ge};
            end
            S_MS: begin
                r_diff <= w_ms - $signed({35'd0, i_cfg.frame_ms});
            end
            S_SCALE: begin
                r_prod <= r_diff * $signed({1'b0, r_k});
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out_case <= r_pcase;
                    r_out_jump <= r_zero ? 42'sd0 : w_sat;
                    r_out_lost <= r_lost;
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_valid       = r_out_vld;
    assign o_packet_case = r_out_case;
    assign o_offset_jump = r_out_jump;
    assign o_lost_count  = r_out_lost;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RTP packet order classifier core. Headers go in
// over a valid/ready channel; a built-in classifier model predicts case, lost
// count and byte offset jump for each accepted item, and the monitor checks
// every result in order under random idling, back-pressure and several
// register settings.
// ----------------------------------------------------------------------------
module tb_top import rpoc_pkg::*; ;

    localparam int          LIMIT       = 1000000;
    localparam int          HOLD_CYCLES = 500;
    localparam int          MAX_REPORTS = 40;
    localparam longint      SEQ_SPAN    = 65535;
    localparam longint      MS_PER_S    = 1000;

    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] ts;
        logic [6:0]  pt;
    } t_hdr;

    typedef struct packed {
        logic [2:0]         pcase;
        logic signed [41:0] jump;
        logic signed [16:0] lost;
    } t_verdict;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_idx      = '0;
    logic [CfgDataW-1:0]  i_cfg_data     = '0;
    logic                 i_valid        = 1'b0;
    logic                 o_ready;
    logic [15:0]          i_seq_num      = '0;
    logic [31:0]          i_timestamp    = '0;
    logic [6:0]           i_payload_type = '0;
    logic                 o_valid;
    logic                 i_ready        = 1'b0;
    logic [2:0]           o_packet_case;
    logic signed [41:0]   o_offset_jump;
    logic signed [16:0]   o_lost_count;

    rtp_packet_order_classifier_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_seq_num      (i_seq_num),
        .i_timestamp    (i_timestamp),
        .i_payload_type (i_payload_type),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_packet_case  (o_packet_case),
        .o_offset_jump  (o_offset_jump),
        .o_lost_count   (o_lost_count)
    );

    always #1 i_clk = ~i_clk;

    // classifier model: registers and last accepted header
    logic [17:0] cfg_codec_rate    = CODEC_RATE_RST;
    logic [7:0]  cfg_frame_ms      = FRAME_MS_RST;
    logic [15:0] cfg_frame_samples = FRAME_SAMPLES_RST;
    logic [11:0] cfg_seq_limit     = SEQ_LIMIT_RST;
    logic [7:0]  cfg_out_rate      = OUT_RATE_KHZ_RST;
    logic [3:0]  cfg_bps           = BYTES_PER_SAMPLE_RST;
    logic [7:0]  last_pt           = PT_NONE;
    logic [31:0] last_ts           = '0;
    logic [15:0] last_seq          = '0;

    t_hdr     hdr_queue[$];
    t_verdict expected_verdicts[$];

    int  err_cnt      = 0;
    int  n_in         = 0;
    int  n_out        = 0;
    int  n_settings   = 0;
    int  stall_cycles = 0;
    int  cycle_cnt    = 0;
    int  case_seen[5] = '{default: 0};
    bit  no_idle      = 1'b0;
    bit  hold_armed   = 1'b0;
    int  hold_at      = 0;
    int  hold_left    = 0;

    // stimulus generator state
    logic [15:0] g_seq = '0;
    logic [31:0] g_ts  = '0;
    logic [6:0]  g_pt  = '0;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_verdict classify_packet(t_hdr h);
        t_verdict    v;
        longint      d, t, ms, jmp, lost_w;
        logic [31:0] tdiff;
        v.pcase = PCASE_NEW;
        v.jump  = '0;
        v.lost  = '0;
        if ({1'b0, h.pt} != last_pt) begin
            last_pt  = {1'b0, h.pt};
            last_ts  = h.ts;
            last_seq = h.seq;
            return v;
        end
        d = longint'(h.seq) - longint'(last_seq);
        // 16-bit wrap: move a near-full-span distance back toward zero
        if (mag(d) > SEQ_SPAN - longint'(cfg_seq_limit))
            d = (d > 0) ? d - (SEQ_SPAN + 1) : d + (SEQ_SPAN + 1);
        tdiff = h.ts - last_ts;
        t = longint'(signed'(tdiff));
        ms = (cfg_codec_rate == 0) ? 0 : (t * MS_PER_S) / longint'(cfg_codec_rate);
        jmp = (ms - longint'(cfg_frame_ms)) * longint'(cfg_out_rate) * longint'(cfg_bps);
        if (jmp > OFFSET_MAX)
            jmp = OFFSET_MAX;
        if (jmp < OFFSET_MIN)
            jmp = OFFSET_MIN;
        if (mag(t) > longint'(cfg_seq_limit) * longint'(cfg_frame_samples) ||
            mag(d) > longint'(cfg_seq_limit))
            v.pcase = PCASE_NEW;
        else if (d > 1)
            v.pcase = PCASE_JUMP;
        else if (d == 1)
            v.pcase = PCASE_NEXT;
        else if (d < 0)
            v.pcase = PCASE_OLD;
        else
            v.pcase = PCASE_DUP;
        if (v.pcase != PCASE_OLD) begin
            last_ts  = h.ts;
            last_seq = h.seq;
        end
        lost_w = d - 1;
        v.jump = jmp[41:0];
        v.lost = lost_w[16:0];
        return v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (err_cnt < MAX_REPORTS)
            $display("MISMATCH result %0d %s: got %0d, expected %0d", n_out, what, got, want);
        err_cnt++;
    endtask

    task automatic push_hdr(logic [15:0] seq, logic [31:0] ts, logic [6:0] pt);
        t_hdr h;
        h.seq = seq;
        h.ts  = ts;
        h.pt  = pt;
        hdr_queue.push_back(h);
    endtask

    task automatic wait_drain();
        while (hdr_queue.size() != 0 || i_valid || expected_verdicts.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CODEC_RATE:       cfg_codec_rate    = val[17:0];
            CFG_FRAME_MS:         cfg_frame_ms      = val[7:0];
            CFG_FRAME_SAMPLES:    cfg_frame_samples = val[15:0];
            CFG_SEQ_LIMIT:        cfg_seq_limit     = val[11:0];
            CFG_OUT_RATE_KHZ:     cfg_out_rate      = val[7:0];
            CFG_BYTES_PER_SAMPLE: cfg_bps           = val[3:0];
            default: ;
        endcase
    endtask

    // only called with the block drained
    task automatic apply_cfg(int unsigned cr, int unsigned fm, int unsigned fs,
                             int unsigned md, int unsigned orate, int unsigned bps);
        write_reg(CFG_CODEC_RATE, CfgDataW'(cr));
        write_reg(CFG_FRAME_MS, CfgDataW'(fm));
        write_reg(CFG_FRAME_SAMPLES, CfgDataW'(fs));
        write_reg(CFG_SEQ_LIMIT, CfgDataW'(md));
        write_reg(CFG_OUT_RATE_KHZ, CfgDataW'(orate));
        write_reg(CFG_BYTES_PER_SAMPLE, CfgDataW'(bps));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        n_settings++;
    endtask

    // mostly well-formed streams with random content, some noise
    task automatic gen_traffic(int n);
        int unsigned r, k, ts_step, span;
        ts_step = (cfg_frame_samples == 0) ? 1 : cfg_frame_samples;
        span    = (cfg_seq_limit < 2) ? 2 : cfg_seq_limit;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                g_seq = g_seq + 16'd1;
                g_ts  = g_ts + ts_step;
                push_hdr(g_seq, g_ts, g_pt);
            end else if (r < 60) begin
                k = $urandom_range(span, 2);
                g_seq = g_seq + 16'(k);
                if ($urandom_range(1))
                    g_ts = g_ts + ts_step * k;
                push_hdr(g_seq, g_ts, g_pt);
            end else if (r < 68) begin
                k = $urandom_range(8, 1);
                push_hdr(g_seq - 16'(k), g_ts - ts_step * k, g_pt);
            end else if (r < 74) begin
                push_hdr(g_seq, g_ts, g_pt);
            end else if (r < 80) begin
                g_seq = g_seq + 16'd1;
                g_ts  = g_ts + $urandom_range(2 * ts_step);
                push_hdr(g_seq, g_ts, g_pt);
            end else if (r < 85) begin
                g_seq = g_seq + 16'($urandom);
                g_ts  = g_ts + $urandom;
                push_hdr(g_seq, g_ts, g_pt);
            end else if (r < 90) begin
                g_pt  = 7'($urandom_range(127));
                g_seq = 16'($urandom_range(1) ? $urandom_range(65535, 65500) : $urandom);
                g_ts  = $urandom;
                push_hdr(g_seq, g_ts, g_pt);
            end else begin
                push_hdr(16'($urandom), $urandom,
                         $urandom_range(1) ? g_pt : 7'($urandom_range(127)));
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_hdr h;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                h.seq = i_seq_num;
                h.ts  = i_timestamp;
                h.pt  = i_payload_type;
                expected_verdicts.push_back(classify_packet(h));
                n_in++;
            end
            if (i_valid && !o_ready)
                stall_cycles++;
            if (!i_valid || o_ready) begin
                if (hdr_queue.size() != 0 && (no_idle || $urandom_range(99) >= 33)) begin
                    h = hdr_queue.pop_front();
                    i_valid        <= 1'b1;
                    i_seq_num      <= h.seq;
                    i_timestamp    <= h.ts;
                    i_payload_type <= h.pt;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_armed && n_in >= hold_at) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("unexpected item, packet_case", o_packet_case, -1);
                end else begin
                    want = expected_verdicts.pop_front();
                    case_seen[want.pcase]++;
                    if (o_packet_case !== want.pcase)
                        report_mismatch("packet_case", o_packet_case, want.pcase);
                    if (o_offset_jump !== want.jump)
                        report_mismatch("offset_jump", o_offset_jump, want.jump);
                    if (o_lost_count !== want.lost)
                        report_mismatch("lost_count", o_lost_count, want.lost);
                end
                n_out++;
            end
            i_ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 33);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset register values
        push_hdr(16'd100, 32'd1000, 7'd0);              // first item after reset
        push_hdr(16'd101, 32'd1160, 7'd0);              // next
        push_hdr(16'd105, 32'd1800, 7'd0);              // jump
        push_hdr(16'd103, 32'd1480, 7'd0);              // old, state kept
        push_hdr(16'd105, 32'd1800, 7'd0);              // duplicate
        push_hdr(16'd65534, 32'd5000, 7'd127);          // payload type change
        push_hdr(16'd65535, 32'd5160, 7'd127);
        push_hdr(16'd0, 32'd5320, 7'd127);              // seq wraps forward
        push_hdr(16'd65535, 32'd5160, 7'd127);          // seq wraps backward: old
        push_hdr(16'd10, 32'd5480, 7'd127);
        push_hdr(16'd1000, 32'd5640, 7'd127);           // seq too far
        push_hdr(16'd1001, 32'd13641, 7'd127);          // timestamp too far
        push_hdr(16'd1002, 32'hFFFF_FFFF, 7'd127);      // large negative t
        push_hdr(16'd1003, 32'h0000_0000, 7'd127);      // t wraps to +1
        push_hdr(16'd65535, 32'h8000_0000, 7'd0);
        push_hdr(16'd0, 32'h7FFF_FFFF, 7'd0);           // negative t, truncating ms
        push_hdr(16'd0, 32'h7FFF_FFFF, 7'd0);
        push_hdr(16'd0, 32'h0000_0000, 7'd0);
        push_hdr(16'hAAAA, 32'h5555_5555, 7'h55);
        push_hdr(16'h5555, 32'hAAAA_AAAA, 7'h2A);
        wait_drain();

        // zero codec rate
        apply_cfg(0, 20, 160, 50, 48, 2);
        push_hdr(16'd200, 32'd100, 7'd3);
        push_hdr(16'd201, 32'd260, 7'd3);
        wait_drain();

        // zero max difference: no wrap correction, any step is a new flow
        apply_cfg(8000, 20, 160, 0, 48, 2);
        push_hdr(16'd300, 32'd500, 7'd4);
        push_hdr(16'd300, 32'd500, 7'd4);
        push_hdr(16'd301, 32'd660, 7'd4);
        push_hdr(16'd65535, 32'd660, 7'd4);
        wait_drain();

        // offset saturation both ways
        apply_cfg(1, 255, 65535, 4095, 255, 15);
        push_hdr(16'd0, 32'h0000_0000, 7'd5);
        push_hdr(16'd1, 32'h7FFF_FFFF, 7'd5);
        push_hdr(16'd2, 32'h0000_0000, 7'd5);
        push_hdr(16'd3, 32'h8000_0000, 7'd5);
        wait_drain();

        // random traffic, first with both sides always ready
        apply_cfg(8000, 20, 160, 50, 48, 2);
        no_idle = 1'b1;
        gen_traffic(250);
        wait_drain();
        no_idle = 1'b0;

        apply_cfg(1000, 1, 1, 1, 1, 1);
        gen_traffic(250);
        wait_drain();

        apply_cfg(192000, 255, 65535, 4095, 192, 8);
        hold_at    = n_in + 30;
        hold_armed = 1'b1;
        gen_traffic(250);
        wait_drain();

        apply_cfg(18'h3FFFF, 255, 65535, 4095, 255, 15);
        gen_traffic(200);
        wait_drain();

        repeat (3) begin
            apply_cfg($urandom_range(192000, 1000), $urandom_range(255, 1),
                      $urandom_range(65535, 1), $urandom_range(4095, 1),
                      $urandom_range(192, 1), $urandom_range(8, 1));
            gen_traffic(200);
            wait_drain();
        end

        // catch any stray result
        repeat (100) @(negedge i_clk);
        if (expected_verdicts.size() != 0)
            report_mismatch("results never delivered", 0, expected_verdicts.size());

        $display("%0d headers checked over %0d register settings: new %0d, next %0d, jump %0d, old %0d, dup %0d",
                 n_out, n_settings, case_seen[PCASE_NEW], case_seen[PCASE_NEXT],
                 case_seen[PCASE_JUMP], case_seen[PCASE_OLD], case_seen[PCASE_DUP]);
        $display("input held off for %0d cycles, %0d mismatches", stall_cycles, err_cnt);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rpoc_pkg.sv
hw/rtl/rpoc_front.sv
hw/rtl/rpoc_queue.sv
hw/rtl/rpoc_back.sv
hw/rtl/rtp_packet_order_classifier_core.sv
dv/tb_top.sv
